[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds on every clock edge outside reset
`define SCL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SCL_ASSERT(label, clk, rst, prop)
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/scl_pkg.sv]
// constants, types and helpers of the command line parser
package scl_pkg;

  localparam int FIELD_CHARS = 15;
  localparam int VALUE_BITS  = 32;
  localparam int NUM_FIELDS  = 4;
  localparam int OUT_BITS    = 32;

  localparam int CHAR_W = $clog2(FIELD_CHARS + 1);
  localparam int SLOT_W = $clog2(NUM_FIELDS);
  localparam int ACC_W  = VALUE_BITS + 4;

  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] SPACE_BYTE = 8'd32;
  localparam logic [7:0] PLUS_BYTE  = 8'h2b;
  localparam logic [7:0] MINUS_BYTE = 8'h2d;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] WS_FIRST   = 8'd9;
  localparam logic [7:0] WS_LAST    = 8'd12;

  // largest magnitude of a negative value, one less for a positive one
  localparam logic [VALUE_BITS-1:0] VHALF = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_WS   = 3'b001,
    PH_DIG  = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]                            command;
    logic [NUM_FIELDS-1:0][OUT_BITS-1:0]   value;
  } result_t;

  // signed value of VALUE_BITS bits, sign-extended or cut to the output width
  function automatic logic [OUT_BITS-1:0] to_output(input logic [VALUE_BITS-1:0] v);
    logic signed [63:0] x;
    x = 64'(signed'(v));
    return x[OUT_BITS-1:0];
  endfunction

endpackage

[rtl/scl_digit_acc.sv]
// saturating decimal accumulate of one digit into a field magnitude
module scl_digit_acc (
  input  logic [scl_pkg::VALUE_BITS-1:0] mag,
  input  logic                           neg,
  input  logic [3:0]                     digit,
  output logic [scl_pkg::VALUE_BITS-1:0] mag_next
);
  import scl_pkg::*;

  logic [ACC_W-1:0] wide;
  logic [ACC_W-1:0] cap;

  always_comb begin
    // mag * 10 + digit as (mag << 3) + (mag << 1) + digit
    wide = (ACC_W'(mag) << 3) + (ACC_W'(mag) << 1) + ACC_W'(digit);
    cap  = neg ? ACC_W'(VHALF) : ACC_W'(VHALF - 1'b1);
    if (wide > cap) begin
      mag_next = cap[VALUE_BITS-1:0];
    end else begin
      mag_next = wide[VALUE_BITS-1:0];
    end
  end

endmodule

[rtl/scl_line_ctrl.sv]
// line state: field tracking, per-field conversion and the finished line
`include "assert_macros.svh"

module scl_line_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       c,
  output logic             fire,
  output scl_pkg::result_t result
);
  import scl_pkg::*;

  logic [2:0]            field_number, field_number_next;
  logic [CHAR_W-1:0]     char_count, char_count_next;
  logic [7:0]            command_hold, command_hold_next;
  logic [VALUE_BITS-1:0] mag [NUM_FIELDS];
  logic [VALUE_BITS-1:0] mag_next [NUM_FIELDS];
  logic [NUM_FIELDS-1:0] neg, neg_next;
  phase_t                phase, phase_next;

  logic [SLOT_W-1:0]     slot;
  logic [VALUE_BITS-1:0] acc;
  logic                  is_ws, is_sign, is_digit;
  logic [VALUE_BITS-1:0] signed_val [NUM_FIELDS];

  assign slot     = SLOT_W'(field_number - 3'd1);
  assign is_ws    = c inside {[WS_FIRST:WS_LAST]};
  assign is_sign  = (c == PLUS_BYTE) || (c == MINUS_BYTE);
  assign is_digit = c inside {[DIGIT_ZERO:DIGIT_NINE]};

  scl_digit_acc u_acc (
    .mag      (mag[slot]),
    .neg      (neg[slot]),
    .digit    (c[3:0]),
    .mag_next (acc)
  );

  always_comb begin
    field_number_next = field_number;
    char_count_next   = char_count;
    command_hold_next = command_hold;
    neg_next          = neg;
    phase_next        = phase;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      mag_next[i] = mag[i];
    end
    fire = 1'b0;
    if (step) begin
      if (c == CR_BYTE) begin
        fire              = 1'b1;
        field_number_next = '0;
        char_count_next   = '0;
        command_hold_next = '0;
        neg_next          = '0;
        phase_next        = PH_WS;
        for (int i = 0; i < NUM_FIELDS; i++) begin
          mag_next[i] = '0;
        end
      end else if (c == SPACE_BYTE) begin
        // last field runs on across spaces
        if (field_number < 3'(NUM_FIELDS)) begin
          field_number_next = field_number + 3'd1;
          char_count_next   = '0;
          phase_next        = PH_WS;
        end
      end else if (field_number == 3'd0) begin
        command_hold_next = c;
      end else if (char_count < CHAR_W'(FIELD_CHARS)) begin
        char_count_next = char_count + 1'b1;
        case (phase)
          PH_WS: begin
            if (is_ws) begin
              phase_next = PH_WS;
            end else if (is_sign) begin
              neg_next[slot] = (c == MINUS_BYTE);
              phase_next     = PH_DIG;
            end else if (is_digit) begin
              mag_next[slot] = acc;
              phase_next     = PH_DIG;
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_DIG: begin
            if (is_digit) begin
              mag_next[slot] = acc;
            end else begin
              phase_next = PH_STOP;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_comb begin
    result.command = command_hold;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      signed_val[i]   = neg[i] ? (VALUE_BITS'(0) - mag[i]) : mag[i];
      result.value[i] = to_output(signed_val[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number <= '0;
      char_count   <= '0;
      command_hold <= '0;
      neg          <= '0;
      phase        <= PH_WS;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        mag[i] <= '0;
      end
    end else begin
      field_number <= field_number_next;
      char_count   <= char_count_next;
      command_hold <= command_hold_next;
      neg          <= neg_next;
      phase        <= phase_next;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        mag[i] <= mag_next[i];
      end
    end
  end

  `SCL_ASSERT(a_field_range, clk, rst, field_number <= 3'(NUM_FIELDS))
  `SCL_ASSERT(a_char_range, clk, rst, char_count <= CHAR_W'(FIELD_CHARS))
  `SCL_ASSERT_NEXT(a_clear_after_line, clk, rst, fire, field_number == 3'd0 && command_hold == 8'd0 && neg == '0)
  `SCL_ASSERT_NEXT(a_cmd_only_in_field0, clk, rst, step && c != CR_BYTE && field_number != 3'd0, $stable(command_hold))

endmodule

[rtl/serial_command_line_parser_unit.sv]
// top level of the serial command line parser
// result path: a line's carriage return passes the input register, then the result
//   register, where its result beat is held valid until it is taken
// throughput: one byte per cycle; a carriage return waits in the input register
//   only while the result register still holds an untaken line
// reset: synchronous, clears all line state and both valid flags at once
`include "assert_macros.svh"

module serial_command_line_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         command_code,
  output logic signed [31:0] value_one,
  output logic signed [31:0] value_two,
  output logic signed [31:0] value_three,
  output logic signed [31:0] value_four
);
  import scl_pkg::*;

  // input register: one received byte waiting for the state update
  logic       in_v;
  logic [7:0] in_byte;

  // a byte leaves the input register unless it is a line end and the
  // result register cannot take a new line this cycle
  logic    advance;
  logic    fire;
  result_t result;
  result_t out_q;

  assign advance  = in_v && ((in_byte != CR_BYTE) || !out_valid || out_ready);
  assign in_ready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ready) begin
      in_v <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  scl_line_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .c      (in_byte),
    .fire   (fire),
    .result (result)
  );

  // result register: holds the finished line until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign command_code = out_q.command;
  assign value_one    = signed'(out_q.value[0]);
  assign value_two    = signed'(out_q.value[1]);
  assign value_three  = signed'(out_q.value[2]);
  assign value_four   = signed'(out_q.value[3]);

  // a held byte stays put until it can be processed
  `SCL_ASSERT_NEXT(a_stall_holds, clk, rst, in_v && !advance, in_v && $stable(in_byte))
  // a new line never overwrites an untaken result
  `SCL_ASSERT(a_no_overwrite, clk, rst, !(fire && out_valid && !out_ready))
  // every finished line shows up as a result beat
  `SCL_ASSERT_NEXT(a_fire_shows, clk, rst, fire, out_valid)

endmodule
